[rtl/pfe_pkg.sv]
// pfe_pkg: shared types, codes, constants and digit helper of the printf format engine
// no dependencies
package pfe_pkg;

  localparam int PFE_MAX_WIDTH = 63;
  localparam int PFE_ARG_BITS  = 64;
  localparam int PFE_ARG_W     = 64;
  localparam int PFE_NDIG      = 22;   // octal of 64 bits needs the most digits
  localparam int PFE_DIGS_W    = 4 * PFE_NDIG;

  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_UC_A  = 8'h41;

  // flag bit positions
  localparam int FL_ALT   = 0;
  localparam int FL_ZERO  = 1;
  localparam int FL_LEFT  = 2;
  localparam int FL_SPACE = 3;
  localparam int FL_PLUS  = 4;

  typedef enum logic [3:0] {
    LK_DEFAULT = 4'd0,
    LK_H_PEND  = 4'd1,
    LK_L_PEND  = 4'd2,
    LK_HH      = 4'd3,
    LK_H       = 4'd4,
    LK_L       = 4'd5,
    LK_LL      = 4'd6,
    LK_BIGL    = 4'd7,
    LK_T       = 4'd8
  } len_kind_t;

  typedef enum logic [5:0] {
    P_IDLE  = 6'b000001,
    P_FLAG  = 6'b000010,
    P_WIDTH = 6'b000100,
    P_PREC  = 6'b001000,
    P_LEN   = 6'b010000,
    P_CONV  = 6'b100000
  } parse_st_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DAB  = 4'b0010,
    S_SCAN = 4'b0100,
    S_EMIT = 4'b1000
  } seq_st_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] r;
    if (d < 4'd10) begin
      r = CH_ZERO + {4'd0, d};
    end else begin
      r = (upper ? CH_UC_A : CH_LC_A) + {4'd0, d} - 8'd10;
    end
    return r;
  endfunction

endpackage

[rtl/pfe_in_if.sv]
// pfe_in_if: format input channel, valid/ready handshake
// depends on pfe_pkg
interface pfe_in_if;
  import pfe_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 mode;
  logic [7:0]           ch;
  logic [PFE_ARG_W-1:0] arg_value;
  modport source(output valid, mode, ch, arg_value, input ready);
  modport sink(input valid, mode, ch, arg_value, output ready);
endinterface

[rtl/pfe_out_if.sv]
// pfe_out_if: output byte channel, valid/ready handshake
// no dependencies
interface pfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last;
  modport source(output valid, out_char, last, input ready);
  modport sink(input valid, out_char, last, output ready);
endinterface

[rtl/printf_format_engine.sv]
// printf_format_engine: top level of the byte-serial printf formatter
// depends on pfe_pkg, pfe_in_if, pfe_out_if
// A literal format byte is taken and its echo is loaded into the output
// register. A specifier byte that only changes parse state just updates the
// parser registers. An integer conversion runs a small sequencer around one
// shared digit unit: decimal goes through a shift-and-add-3 converter, then a
// leading-zero scan drops zero digits, works out the padding and hands over
// to emission, then one byte leaves per cycle while the output is not stalled,
// for max(width, digits + sign) bytes (at most 63); hex and octal skip the
// converter. fmt.ready stays low throughout. A new item is taken while the
// previous byte still waits in the output register only once that byte is
// being transferred in the same cycle.
module printf_format_engine
  import pfe_pkg::*;
#(
  parameter int MAX_WIDTH = PFE_MAX_WIDTH,
  parameter int ARG_BITS  = PFE_ARG_BITS
) (
  input logic       clk,
  input logic       rst,
  pfe_in_if.sink    fmt,
  pfe_out_if.source res
);

  localparam logic [PFE_ARG_W-1:0] MASK_L = {PFE_ARG_W{1'b1}} >> (PFE_ARG_W - ARG_BITS);
  localparam logic [9:0] MAX_W10 = 10'(MAX_WIDTH);

  // parser state
  parse_st_t        pstate, pstate_next;
  logic [4:0]       flags, flags_next;
  logic [5:0]       width, width_next;
  len_kind_t        lkind, lkind_next;

  // sequencer and shared digit unit
  seq_st_t          seq, seq_next;
  logic [PFE_ARG_W-1:0] mag;
  logic [PFE_DIGS_W-1:0] digs;
  logic [5:0]       dab_cnt;
  logic [4:0]       len;
  logic [5:0]       pad;
  logic [6:0]       total;
  logic [7:0]       sign_b;
  logic             upper;
  logic             prep;   // scan finished and padding worked out, emission follows

  // output register
  logic             ov;
  logic [7:0]       oc;
  logic             ol;

  logic             out_free, acc;
  assign out_free  = !ov || res.ready;
  assign fmt.ready = (seq == S_IDLE) && out_free;
  assign acc       = fmt.valid && fmt.ready;
  assign res.valid = ov;
  assign res.out_char = oc;
  assign res.last  = ol;

  // parse decode of the accepted byte
  logic       do_w, do_l, do_c, taken;
  logic       echo;
  logic [7:0] echo_b;
  logic       start_num;
  logic       num_dec, num_oct;
  logic [9:0] wsum;
  len_kind_t  lk_use;
  logic [PFE_ARG_W-1:0] v, mk, mag_n;
  logic       sb, ok;
  logic [7:0] sign_n;
  logic [7:0] c;

  always_comb begin
    c = fmt.ch;
    pstate_next = pstate;
    flags_next = flags;
    width_next = width;
    lkind_next = lkind;
    do_w = 1'b0;
    do_l = 1'b0;
    do_c = 1'b0;
    taken = 1'b0;
    echo = 1'b0;
    echo_b = c;
    start_num = 1'b0;
    num_dec = 1'b0;
    num_oct = 1'b0;
    lk_use = lkind;
    wsum = 10'd0;
    v = '0;
    mk = '0;
    sb = 1'b0;
    ok = 1'b1;
    mag_n = '0;
    sign_n = 8'd0;
    case (pstate)
      P_FLAG: begin
        case (c)
          CH_HASH:  flags_next[FL_ALT] = 1'b1;
          CH_ZERO:  flags_next[FL_ZERO] = 1'b1;
          CH_MINUS: flags_next[FL_LEFT] = 1'b1;
          CH_SPACE: flags_next[FL_SPACE] = 1'b1;
          CH_PLUS:  flags_next[FL_PLUS] = 1'b1;
          default:  do_w = 1'b1;
        endcase
      end
      P_WIDTH: do_w = 1'b1;
      P_PREC: begin
        if (!(c >= CH_ZERO && c <= CH_NINE)) begin
          do_l = 1'b1;
        end
      end
      P_LEN:  do_l = 1'b1;
      P_CONV: do_c = 1'b1;
      default: begin
        if (c == CH_PCT) begin
          pstate_next = P_FLAG;
          flags_next = '0;
          width_next = '0;
          lkind_next = LK_DEFAULT;
        end else begin
          pstate_next = P_IDLE;
          echo = 1'b1;
        end
      end
    endcase

    if (do_w) begin
      if (c >= CH_ZERO && c <= CH_NINE) begin
        wsum = 10'(width) * 10'd10 + 10'(c - CH_ZERO);
        width_next = (wsum > MAX_W10) ? 6'(MAX_WIDTH) : wsum[5:0];
        pstate_next = P_WIDTH;
      end else if (c == CH_DOT) begin
        pstate_next = P_PREC;
      end else begin
        do_l = 1'b1;
      end
    end

    if (do_l) begin
      case (lkind)
        LK_DEFAULT: begin
          taken = 1'b1;
          if (c == "h") lk_use = LK_H_PEND;
          else if (c == "l") lk_use = LK_L_PEND;
          else if (c == "L") lk_use = LK_BIGL;
          else if (c == "t") lk_use = LK_T;
          else taken = 1'b0;
        end
        LK_H_PEND: begin
          if (c == "h") begin
            lk_use = LK_HH;
            taken = 1'b1;
          end else begin
            lk_use = LK_H;
          end
        end
        LK_L_PEND: begin
          if (c == "l") begin
            lk_use = LK_LL;
            taken = 1'b1;
          end else begin
            lk_use = LK_L;
          end
        end
        default: lk_use = lkind;
      endcase
      lkind_next = lk_use;
      if (taken) begin
        pstate_next = (lk_use == LK_H_PEND || lk_use == LK_L_PEND) ? P_LEN : P_CONV;
      end else begin
        do_c = 1'b1;
      end
    end

    // argument width per length, sign bit and magnitude
    case (lk_use)
      LK_HH: begin
        mk = {{(PFE_ARG_W-8){1'b0}}, 8'hFF};
        sb = fmt.arg_value[7];
      end
      LK_H: begin
        mk = {{(PFE_ARG_W-16){1'b0}}, 16'hFFFF};
        sb = fmt.arg_value[15];
      end
      LK_DEFAULT: begin
        mk = {{(PFE_ARG_W-32){1'b0}}, 32'hFFFF_FFFF};
        sb = fmt.arg_value[31];
      end
      LK_L: begin
        mk = MASK_L;
        sb = fmt.arg_value[ARG_BITS-1];
      end
      LK_LL: begin
        mk = '1;
        sb = fmt.arg_value[PFE_ARG_W-1];
      end
      default: ok = 1'b0;
    endcase
    v = fmt.arg_value & mk;

    if (do_c) begin
      pstate_next = P_IDLE;
      case (c)
        "d", "i": begin
          start_num = 1'b1;
          num_dec = 1'b1;
          if (ok && sb) begin
            mag_n = (~v + 1'b1) & mk;
            sign_n = CH_MINUS;
          end else begin
            mag_n = v;
            if (flags[FL_PLUS]) sign_n = CH_PLUS;
            else if (flags[FL_SPACE]) sign_n = CH_SPACE;
          end
        end
        "u": begin
          start_num = 1'b1;
          num_dec = 1'b1;
          mag_n = v;
        end
        "o": begin
          start_num = 1'b1;
          num_oct = 1'b1;
          mag_n = v;
        end
        "x", "X": begin
          start_num = 1'b1;
          mag_n = v;
        end
        "e", "E", "f", "F", "g", "G", "a", "A", "p", "n": ;
        "c": begin
          echo = 1'b1;
          echo_b = fmt.arg_value[7:0];
        end
        default: echo = 1'b1;
      endcase
    end

    if (fmt.mode) begin
      pstate_next = P_IDLE;
      flags_next = '0;
      width_next = '0;
      lkind_next = LK_DEFAULT;
      echo = 1'b0;
      start_num = 1'b0;
    end
  end

  // octal digit spread into nibbles
  logic [PFE_DIGS_W-1:0] oct_digs;
  logic [3*PFE_NDIG-1:0] mag_oct;
  assign mag_oct = (3*PFE_NDIG)'(mag_n);
  always_comb begin
    for (int i = 0; i < PFE_NDIG; i++) begin
      oct_digs[4*i +: 4] = {1'b0, mag_oct[3*i +: 3]};
    end
  end

  // shift-and-add-3 step over the decimal digits
  logic [79:0] bcd_adj;
  always_comb begin
    for (int i = 0; i < 20; i++) begin
      bcd_adj[4*i +: 4] = (digs[4*i +: 4] >= 4'd5) ? digs[4*i +: 4] + 4'd3
                                                   : digs[4*i +: 4];
    end
  end

  // emission choice
  logic       lead_sp, lead_z;
  logic [7:0] emit_b;
  logic       emit;
  logic [5:0] lws;
  assign lead_sp = !flags[FL_LEFT] && !flags[FL_ZERO] && (pad != 6'd0);
  assign lead_z  = !flags[FL_LEFT] && flags[FL_ZERO] && (pad != 6'd0);
  assign emit    = (seq == S_EMIT) && out_free;
  assign lws     = 6'(len) + ((sign_b != 8'd0) ? 6'd1 : 6'd0);

  always_comb begin
    if (lead_sp) emit_b = CH_SPACE;
    else if (sign_b != 8'd0) emit_b = sign_b;
    else if (lead_z) emit_b = CH_ZERO;
    else if (len != 5'd0) emit_b = digit_char(digs[PFE_DIGS_W-1 -: 4], upper);
    else emit_b = CH_SPACE;
  end

  always_comb begin
    seq_next = seq;
    case (seq)
      S_IDLE: begin
        if (acc && start_num) seq_next = !ok ? S_SCAN : (num_dec ? S_DAB : S_SCAN);
      end
      S_DAB:  if (dab_cnt == 6'd0) seq_next = S_SCAN;
      S_SCAN: begin
        if (prep) seq_next = (total == 7'd0) ? S_IDLE : S_EMIT;
      end
      S_EMIT: if (emit && total == 7'd1) seq_next = S_IDLE;
      default: seq_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pstate <= P_IDLE;
      flags <= '0;
      width <= '0;
      lkind <= LK_DEFAULT;
      seq <= S_IDLE;
      ov <= 1'b0;
      prep <= 1'b0;
    end else begin
      seq <= seq_next;
      if (acc) begin
        pstate <= pstate_next;
        flags <= flags_next;
        width <= width_next;
        lkind <= lkind_next;
      end
      // output register
      if (acc && echo) begin
        ov <= 1'b1;
        oc <= echo_b;
        ol <= 1'b1;
      end else if (emit) begin
        ov <= 1'b1;
        oc <= emit_b;
        ol <= (total == 7'd1);
      end else if (res.ready) begin
        ov <= 1'b0;
      end
      case (seq)
        S_IDLE: begin
          prep <= 1'b0;
          if (acc && start_num) begin
            mag <= mag_n;
            sign_b <= sign_n;
            upper <= (c == "X");
            dab_cnt <= 6'd63;
            if (!ok) begin
              len <= 5'd0;
              digs <= '0;
            end else begin
              len <= 5'(PFE_NDIG);
              if (num_dec) digs <= '0;
              else if (num_oct) digs <= oct_digs;
              else digs <= PFE_DIGS_W'(mag_n);
            end
          end
        end
        S_DAB: begin
          digs <= {8'd0, bcd_adj[78:0], mag[PFE_ARG_W-1]};
          mag <= mag << 1;
          dab_cnt <= dab_cnt - 6'd1;
        end
        S_SCAN: begin
          if (!prep) begin
            if (len > 5'd1 && digs[PFE_DIGS_W-1 -: 4] == 4'd0) begin
              digs <= digs << 4;
              len <= len - 5'd1;
            end else begin
              prep <= 1'b1;
              pad <= (width > lws) ? width - lws : 6'd0;
              total <= (width > lws) ? 7'(width) : 7'(lws);
            end
          end
        end
        S_EMIT: begin
          prep <= 1'b0;
          if (emit) begin
            total <= total - 7'd1;
            if (lead_sp) pad <= pad - 6'd1;
            else if (sign_b != 8'd0) sign_b <= 8'd0;
            else if (lead_z) pad <= pad - 6'd1;
            else if (len != 5'd0) begin
              len <= len - 5'd1;
              digs <= digs << 4;
            end else pad <= pad - 6'd1;
          end
        end
        default: prep <= 1'b0;
      endcase
    end
  end

endmodule

[rtl/pfe_checker.sv]
// pfe_checker: port-level checks of the printf format engine, with its bind
// depends on printf_format_engine
module pfe_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_mode,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       out_last
);

  // a stalled byte stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output byte withdrawn while stalled");

  // a stalled byte keeps its value
  a_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_char) && $stable(out_last))
    else $error("output byte changed while stalled");

  // nothing offered straight after reset
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // end of string produces no byte
  a_end: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_mode |=> !out_valid)
    else $error("byte produced by end of string");

endmodule

bind printf_format_engine pfe_checker u_pfe_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (fmt.valid),
  .in_ready (fmt.ready),
  .in_mode  (fmt.mode),
  .out_valid(res.valid),
  .out_ready(res.ready),
  .out_char (res.out_char),
  .out_last (res.last)
);

[tb/testbench.sv]
// testbench: self-checking bench for the printf format engine
// depends on pfe_pkg, pfe_in_if, pfe_out_if and printf_format_engine
// a behavioural formatter predicts each output byte, the checker compares
module testbench;
  import pfe_pkg::*;

  localparam int      N_RANDOM    = 190;
  localparam int      CYCLE_LIMIT = 1500000;
  localparam int      SETTLE      = 250;   // longest conversion with no output
  localparam int      LONG_HOLD   = 400;

  typedef enum int {
    PS_IDLE, PS_FLAG, PS_WIDTH, PS_PREC, PS_LEN, PS_CONV
  } spec_phase_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
  } out_byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pfe_in_if  fmt();
  pfe_out_if res();

  printf_format_engine i_dut (
    .clk (clk),
    .rst (rst),
    .fmt (fmt),
    .res (res)
  );

  always #10 clk = ~clk;

  // predictor state, mirrors the parser of the block
  spec_phase_t phase;
  logic [4:0]  flags;
  int          fwidth;
  len_kind_t   lkind;

  out_byte_t   pending_bytes[$];
  int          step_n;

  int  errors      = 0;
  int  cycles      = 0;
  int  hold_left   = 0;
  int  rx_wait     = 0;
  bit  calm        = 1'b0;

  // ---------------------------------------------------------------------
  // formatter model
  // ---------------------------------------------------------------------
  function automatic void put_byte(logic [7:0] c);
    out_byte_t b;
    if (step_n < 64) begin
      b.out_char = c;
      b.last     = 1'b0;
      pending_bytes.push_back(b);
      step_n++;
    end
  endfunction

  function automatic int arg_width();
    case (lkind)
      LK_HH:      return 8;
      LK_H:       return 16;
      LK_DEFAULT: return 32;
      LK_L:       return PFE_ARG_BITS;
      LK_LL:      return 64;
      default:    return 0;
    endcase
  endfunction

  function automatic logic [63:0] mask_of(int bits);
    if (bits >= 64) return '1;
    return (64'd1 << bits) - 64'd1;
  endfunction

  function automatic void format_number(logic [63:0] mag, bit has_digits, int base,
                                        bit upper, logic [7:0] sign);
    logic [7:0]  dig[64];
    logic [63:0] d;
    int          len;
    int          pad;
    bit          left;
    bit          zero;
    len  = 0;
    pad  = 0;
    left = flags[FL_LEFT];
    zero = flags[FL_ZERO];
    if (has_digits) begin
      do begin
        d = mag % base;
        if (d < 10) dig[len] = CH_ZERO + d[7:0];
        else dig[len] = (upper ? CH_UC_A : CH_LC_A) + d[7:0] - 8'd10;
        len++;
        mag = mag / base;
      end while (mag != 0 && len < 64);
    end
    if (fwidth > len + (sign != 0 ? 1 : 0)) pad = fwidth - len - (sign != 0 ? 1 : 0);
    if (!left && !zero) repeat (pad) put_byte(CH_SPACE);
    if (sign != 0) put_byte(sign);
    if (!left && zero) repeat (pad) put_byte(CH_ZERO);
    for (int i = len; i > 0; i--) put_byte(dig[i-1]);
    if (left) repeat (pad) put_byte(CH_SPACE);
  endfunction

  function automatic void convert_arg(logic [7:0] c, logic [63:0] a);
    int          bits;
    logic [63:0] v;
    logic [63:0] mag;
    logic [7:0]  sign;
    bit          ok;
    bits  = arg_width();
    v     = a & mask_of(bits);
    ok    = bits != 0;
    sign  = 8'd0;
    mag   = v;
    phase = PS_IDLE;
    case (c)
      "d", "i": begin
        if (ok && v[bits-1]) begin
          mag  = (~v + 64'd1) & mask_of(bits);
          sign = CH_MINUS;
        end else if (flags[FL_PLUS]) begin
          sign = CH_PLUS;
        end else if (flags[FL_SPACE]) begin
          sign = CH_SPACE;
        end
        format_number(mag, ok, 10, 1'b0, sign);
      end
      "u": format_number(v, ok, 10, 1'b0, 8'd0);
      "o": format_number(v, ok, 8, 1'b0, 8'd0);
      "x": format_number(v, ok, 16, 1'b0, 8'd0);
      "X": format_number(v, ok, 16, 1'b1, 8'd0);
      "e", "E", "f", "F", "g", "G", "a", "A", "p", "n": ;
      "c": put_byte(a[7:0]);
      default: put_byte(c);
    endcase
  endfunction

  function automatic void take_length(logic [7:0] c, logic [63:0] a);
    bit taken;
    taken = 1'b0;
    if (lkind == LK_DEFAULT) begin
      taken = 1'b1;
      if (c == "h") lkind = LK_H_PEND;
      else if (c == "l") lkind = LK_L_PEND;
      else if (c == "L") lkind = LK_BIGL;
      else if (c == "t") lkind = LK_T;
      else taken = 1'b0;
    end else if (lkind == LK_H_PEND) begin
      if (c == "h") begin
        lkind = LK_HH;
        taken = 1'b1;
      end else lkind = LK_H;
    end else if (lkind == LK_L_PEND) begin
      if (c == "l") begin
        lkind = LK_LL;
        taken = 1'b1;
      end else lkind = LK_L;
    end
    if (taken) phase = (lkind == LK_H_PEND || lkind == LK_L_PEND) ? PS_LEN : PS_CONV;
    else convert_arg(c, a);
  endfunction

  function automatic void take_width(logic [7:0] c, logic [63:0] a);
    if (c >= CH_ZERO && c <= CH_NINE) begin
      fwidth = fwidth * 10 + (c - CH_ZERO);
      if (fwidth > PFE_MAX_WIDTH) fwidth = PFE_MAX_WIDTH;
      phase = PS_WIDTH;
    end else if (c == CH_DOT) begin
      phase = PS_PREC;
    end else begin
      take_length(c, a);
    end
  endfunction

  // work out the bytes that one accepted item causes
  function automatic void predict_item(logic m, logic [7:0] c, logic [63:0] a);
    step_n = 0;
    if (m) begin
      phase  = PS_IDLE;
      flags  = '0;
      fwidth = 0;
      lkind  = LK_DEFAULT;
      return;
    end
    case (phase)
      PS_FLAG: begin
        case (c)
          CH_HASH:  flags[FL_ALT]   = 1'b1;
          CH_ZERO:  flags[FL_ZERO]  = 1'b1;
          CH_MINUS: flags[FL_LEFT]  = 1'b1;
          CH_SPACE: flags[FL_SPACE] = 1'b1;
          CH_PLUS:  flags[FL_PLUS]  = 1'b1;
          default:  take_width(c, a);
        endcase
      end
      PS_WIDTH: take_width(c, a);
      PS_PREC: if (!(c >= CH_ZERO && c <= CH_NINE)) take_length(c, a);
      PS_LEN:   take_length(c, a);
      PS_CONV:  convert_arg(c, a);
      default: begin
        if (c == CH_PCT) begin
          phase  = PS_FLAG;
          flags  = '0;
          fwidth = 0;
          lkind  = LK_DEFAULT;
        end else begin
          put_byte(c);
        end
      end
    endcase
    if (step_n > 0) pending_bytes[pending_bytes.size()-1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // sender: called at a falling edge, returns at a falling edge
  // ---------------------------------------------------------------------
  task automatic send_item(logic m, logic [7:0] c, logic [63:0] a);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      fmt.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    fmt.valid     <= 1'b1;
    fmt.mode      <= m;
    fmt.ch        <= c;
    fmt.arg_value <= a;
    do @(posedge clk); while (!fmt.ready);
    predict_item(m, c, a);
    @(negedge clk);
  endtask

  task automatic send_text(string s, logic [63:0] a);
    for (int i = 0; i < s.len(); i++) send_item(1'b0, s[i], a);
  endtask

  // stop offering and wait until every predicted byte has left the block
  task automatic drain();
    fmt.valid <= 1'b0;
    while (pending_bytes.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic logic [63:0] pick_arg();
    case ($urandom_range(0, 7))
      0: return 64'd0;
      1: return '1;
      2: return 64'h8000_0000_0000_0000;
      3: return 64'(signed'(-$urandom_range(1, 300)));
      4: return 64'($urandom_range(0, 999));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // receiver: random stalls, plus a long hold-off on request
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else if (hold_left > 0) begin
      res.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (rx_wait > 0) begin
      res.ready <= 1'b0;
      rx_wait   <= rx_wait - 1;
    end else begin
      res.ready <= 1'b1;
    end
  end

  // checker on every output transfer
  always @(posedge clk) begin
    out_byte_t want;
    if (!rst && res.valid && res.ready) begin
      rx_wait <= calm ? 0 : $urandom_range(0, 5);
      if (pending_bytes.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected byte %h last %b", res.out_char, res.last);
      end else begin
        want = pending_bytes.pop_front();
        if (res.out_char !== want.out_char || res.last !== want.last) begin
          errors++;
          if (errors <= 10)
            $display("byte mismatch: expected %h/%b, got %h/%b",
                     want.out_char, want.last, res.out_char, res.last);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------
  task automatic test_literals();
    send_item(1'b0, 8'h00, '0);
    send_item(1'b0, 8'hFF, '1);
    send_text("A%%", '0);
  endtask

  task automatic test_signs_and_padding();
    send_text("%+05d", 64'd42);
    send_text("% -4i", 64'hFFFF_FFFF);
    send_text("%#8u", 64'd7);
  endtask

  task automatic test_lengths_and_bases();
    send_text("%hhx", 64'h1FF);
    send_text("%hX", 64'hFFFF_ABCD);
    send_text("%llo", '1);
    send_text("%lld", 64'h8000_0000_0000_0000);
    send_text("%+6Ld", 64'd5);
    send_text("%tu", 64'd9);
    send_text("%hhqx", 64'd3);   // letter after hh is the conversion
  endtask

  task automatic test_odd_conversions();
    send_text("%5c", 64'h141);
    send_text("%p%n%f%s", 64'd1);
    send_text("%99.3d", 64'd12);  // width saturates, precision ignored
    send_text("%-1", 64'd0);
    send_item(1'b1, 8'h00, '0);   // end of string inside a specifier
  endtask

  // long receiver hold-off while the sender keeps offering
  task automatic test_back_pressure();
    hold_left = LONG_HOLD;
    send_text("abcdefgh%-20x", '1);
    send_text("%030llu", '1);
    drain();
  endtask

  task automatic test_random_strings();
    string conv_set;
    string flag_set;
    string len_txt;
    int    k;
    int    sent;
    conv_set = "diuoxXcpnfs%";
    flag_set = "#0- +";
    sent = 0;
    while (sent < N_RANDOM) begin
      calm = ($urandom_range(0, 9) == 0);
      k = $urandom_range(0, 9);
      if (k < 7) begin
        send_item(1'b0, CH_PCT, pick_arg());
        sent++;
        repeat ($urandom_range(0, 3)) begin
          send_item(1'b0, flag_set[$urandom_range(0, 4)], pick_arg());
          sent++;
        end
        repeat ($urandom_range(0, 5) == 0 ? 3 : $urandom_range(0, 2)) begin
          send_item(1'b0, CH_ZERO + 8'($urandom_range(0, 9)), pick_arg());
          sent++;
        end
        if ($urandom_range(0, 3) == 0) begin
          send_item(1'b0, CH_DOT, pick_arg());
          send_item(1'b0, CH_ZERO + 8'($urandom_range(0, 9)), pick_arg());
          sent += 2;
        end
        case ($urandom_range(0, 7))
          0: len_txt = "hh";
          1: len_txt = "h";
          2: len_txt = "l";
          3: len_txt = "ll";
          4: len_txt = "L";
          5: len_txt = "t";
          default: len_txt = "";
        endcase
        send_text(len_txt, '0);
        sent += len_txt.len();
        if ($urandom_range(0, 9) == 0) send_item(1'b0, 8'($urandom), pick_arg());
        else send_item(1'b0, conv_set[$urandom_range(0, conv_set.len()-1)], pick_arg());
        sent++;
      end else if (k < 9) begin
        send_item(1'b0, 8'($urandom), pick_arg());
        sent++;
      end else begin
        send_item(1'b1, 8'($urandom), pick_arg());
        sent++;
      end
      if ($urandom_range(0, 40) == 0) drain();
    end
    calm = 1'b0;
  endtask

  initial begin
    fmt.valid     = 1'b0;
    fmt.mode      = 1'b0;
    fmt.ch        = '0;
    fmt.arg_value = '0;
    res.ready     = 1'b0;
    phase  = PS_IDLE;
    flags  = '0;
    fwidth = 0;
    lkind  = LK_DEFAULT;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_literals();
    test_signs_and_padding();
    test_lengths_and_bases();
    test_odd_conversions();
    drain();                     // sender pause until all bytes are out
    test_back_pressure();
    test_random_strings();
    drain();

    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
